### sv/tlpq_pkg.sv
// Shared types and codes for the three-level priority queue.
package tlpq_pkg;

    // Operation codes
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Class limits
    localparam logic [1:0] CLS_LEAST = 2'd2;

    // Fixed field widths of the ports
    localparam int TAG_W = 16;
    localparam int OCC_W = 4;

    // Request beat
    typedef struct packed {
        logic             op;
        logic [1:0]       priority_req;
        logic [TAG_W-1:0] payload;
    } req_t;

    // Response beat
    typedef struct packed {
        logic [1:0]       status;
        logic [TAG_W-1:0] out_payload;
        logic [1:0]       out_priority;
        logic [OCC_W-1:0] occupancy;
    } rsp_t;

    // Command broadcast to every slot cell
    typedef struct packed {
        logic       enq;
        logic       deq;
        logic [1:0] cls;
    } cell_cmd_t;

endpackage

### sv/three_level_priority_queue.sv
// Top level of the three-level priority queue: command port, cell chain and entry count.
// A request's done beat is registered and shows in the cycle after the request is accepted.
// Throughput: one request per cycle; every slot cell updates in parallel, so busy stays low.
// Results cannot be stalled: each response beat is shown for exactly one cycle with done.
// Reset clears the entry count and the done strobe; slot contents are not reset.
// Slots hold nothing meaningful until written; only slots below the count are read.
module three_level_priority_queue
    import tlpq_pkg::*;
#(
    parameter int QUEUE_DEPTH  = 8,
    parameter int PAYLOAD_BITS = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t req,
    output logic busy,
    output logic done,
    output rsp_t rsp
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int TAG_K = (PAYLOAD_BITS < TAG_W) ? PAYLOAD_BITS : TAG_W;
    localparam int OCC_K = (CNT_W < OCC_W) ? CNT_W : OCC_W;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic                    done_reg;
    rsp_t                    rsp_reg;
    rsp_t                    rsp_next;

    logic                    accept;
    logic                    is_full;
    logic                    is_empty;
    cell_cmd_t               cmd;
    logic [PAYLOAD_BITS-1:0] tag_w;

    logic                    keep_q [QUEUE_DEPTH];
    logic [1:0]              prio_q [QUEUE_DEPTH];
    logic [PAYLOAD_BITS-1:0] pay_q  [QUEUE_DEPTH];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign is_full  = (count_reg == DEPTH_C);
    assign is_empty = (count_reg == '0);

    // Decode the request into a cell command
    always_comb
    begin
        cmd.enq = accept && (req.op == OP_ENQ) && !is_full;
        cmd.deq = accept && (req.op == OP_DEQ) && !is_empty;
        cmd.cls = (req.priority_req > CLS_LEAST) ? CLS_LEAST : req.priority_req;
        tag_w   = '0;
        tag_w[TAG_K-1:0] = req.payload[TAG_K-1:0];
    end

    // Chain of slot cells, slot 0 is the head
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_slot
        logic                    lk;
        logic [1:0]              lp;
        logic [PAYLOAD_BITS-1:0] ld;
        logic [1:0]              rp;
        logic [PAYLOAD_BITS-1:0] rd;

        if (i == 0)
        begin : g_head
            assign lk = 1'b1;
            assign lp = prio_q[i];
            assign ld = pay_q[i];
        end
        else
        begin : g_mid
            assign lk = keep_q[i-1];
            assign lp = prio_q[i-1];
            assign ld = pay_q[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign rp = prio_q[i];
            assign rd = pay_q[i];
        end
        else
        begin : g_inner
            assign rp = prio_q[i+1];
            assign rd = pay_q[i+1];
        end

        tlpq_cell #(
            .PAYLOAD_BITS (PAYLOAD_BITS)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .new_pay    (tag_w),
            .occupied   (count_reg > CNT_W'(i)),
            .left_keep  (lk),
            .left_prio  (lp),
            .left_pay   (ld),
            .right_prio (rp),
            .right_pay  (rd),
            .keep       (keep_q[i]),
            .prio       (prio_q[i]),
            .pay        (pay_q[i])
        );
    end

    // Count update and response beat
    always_comb
    begin
        count_next = count_reg;
        if (cmd.enq)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.deq)
        begin
            count_next = count_reg - 1'b1;
        end

        rsp_next = '0;
        if (req.op == OP_ENQ)
        begin
            rsp_next.status = is_full ? ST_FULL : ST_OK;
        end
        else if (is_empty)
        begin
            rsp_next.status = ST_EMPTY;
        end
        else
        begin
            rsp_next.status = ST_OK;
            rsp_next.out_payload[TAG_K-1:0] = pay_q[0][TAG_K-1:0];
            rsp_next.out_priority = prio_q[0];
        end
        rsp_next.occupancy[OCC_K-1:0] = count_next[OCC_K-1:0];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    // Response payload register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    // Count never runs past the number of slots
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count above queue depth");

    // A done beat always follows an accepted request
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("accepted request gave no done beat");

    // A full status only when the queue was and still is full
    a_full_held: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status == ST_FULL) |-> (count_reg == DEPTH_C))
        else $error("full status with free slots");

    // An empty status leaves the queue empty and returns zero fields
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status == ST_EMPTY) |->
            (count_reg == '0 && rsp.out_payload == '0 && rsp.out_priority == '0))
        else $error("empty status with entries or nonzero fields");

endmodule

### sv/tlpq_cell.sv
// One slot cell of the sorted queue: holds an entry and moves it with its neighbours.
module tlpq_cell
    import tlpq_pkg::*;
#(
    parameter int PAYLOAD_BITS = 16
)
(
    input  logic                    clk,
    input  cell_cmd_t               cmd,
    input  logic [PAYLOAD_BITS-1:0] new_pay,
    input  logic                    occupied,
    input  logic                    left_keep,
    input  logic [1:0]              left_prio,
    input  logic [PAYLOAD_BITS-1:0] left_pay,
    input  logic [1:0]              right_prio,
    input  logic [PAYLOAD_BITS-1:0] right_pay,
    output logic                    keep,
    output logic [1:0]              prio,
    output logic [PAYLOAD_BITS-1:0] pay
);

    logic [1:0]              prio_reg;
    logic [1:0]              prio_next;
    logic [PAYLOAD_BITS-1:0] pay_reg;
    logic [PAYLOAD_BITS-1:0] pay_next;

    // Entry stays put on insert when it is as urgent or more than the new one
    assign keep = occupied && (prio_reg <= cmd.cls);

    // Next slot contents: hold, take the new entry, shift back or shift forward
    always_comb
    begin
        prio_next = prio_reg;
        pay_next  = pay_reg;
        if (cmd.enq)
        begin
            if (!keep)
            begin
                if (left_keep)
                begin
                    prio_next = cmd.cls;
                    pay_next  = new_pay;
                end
                else
                begin
                    prio_next = left_prio;
                    pay_next  = left_pay;
                end
            end
        end
        else if (cmd.deq)
        begin
            prio_next = right_prio;
            pay_next  = right_pay;
        end
    end

    // Slot storage, no reset
    always_ff @(posedge clk)
    begin
        prio_reg <= prio_next;
        pay_reg  <= pay_next;
    end

    assign prio = prio_reg;
    assign pay  = pay_reg;

endmodule
